@@ rtl/circular_doubly_linked_list_engine_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the circular doubly linked list engine
// Same-cycle and next-cycle implication checks, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DOUBLY_LINKED_LIST_ENGINE_CORE_MACROS_SVH
`define CIRCULAR_DOUBLY_LINKED_LIST_ENGINE_CORE_MACROS_SVH

// consequent holds in the cycle of the antecedent
`define CDLL_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define CDLL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/cdll_pkg.sv @@
// ----------------------------------------------------------------------------
// cdll_pkg
// Shared types and constants for the linked list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package cdll_pkg;

  localparam int unsigned NODE_SLOTS_DEF = 256;

  typedef enum logic [2:0] {
    CMD_INS_TAIL    = 3'd0,
    CMD_INS_HEAD    = 3'd1,
    CMD_INS_BEFORE  = 3'd2,
    CMD_INS_AFTER   = 3'd3,
    CMD_REMOVE_NODE = 3'd4,
    CMD_REMOVE_HEAD = 3'd5,
    CMD_REMOVE_TAIL = 3'd6
  } cmd_t;

  localparam logic [1:0] ERR_OK     = 2'd0;
  localparam logic [1:0] ERR_EMPTY  = 2'd1;
  localparam logic [1:0] ERR_ABSENT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_LINK,
    ST_UNLINK,
    ST_REPLY
  } state_t;

  typedef struct packed {
    logic accept;
    logic fetch;
    logic fin_link;
    logic fin_unlink;
    logic fin_reply;
  } ctrl_t;

  typedef struct packed {
    logic in_skip;
    logic cur_insert;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

@@ rtl/cdll_ctrl.sv @@
// ----------------------------------------------------------------------------
// cdll_ctrl
// Command sequencer: accept, link fetch, writeback, result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module cdll_ctrl import cdll_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire stat_t stat,
  output ctrl_t      ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = stat.in_skip ? ST_REPLY : ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_next = stat.cur_insert ? ST_LINK : ST_UNLINK;
      end
      ST_LINK, ST_UNLINK, ST_REPLY: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall       = 1'b1;
    ctl            = '0;
    case (state)
      ST_IDLE: begin
        in_stall   = 1'b0;
        ctl.accept = in_valid;
      end
      ST_FETCH:  ctl.fetch      = 1'b1;
      ST_LINK:   ctl.fin_link   = stat.out_free;
      ST_UNLINK: ctl.fin_unlink = stat.out_free;
      ST_REPLY:  ctl.fin_reply  = stat.out_free;
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/cdll_dp.sv @@
// ----------------------------------------------------------------------------
// cdll_dp
// Link stores, head/empty registers, command registers and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cdll_dp import cdll_pkg::*; #(
  parameter int unsigned NODE_SLOTS = NODE_SLOTS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [2:0] command,
  input  wire logic [7:0] node,
  input  wire logic [7:0] referent,
  input  wire ctrl_t      ctl,
  output stat_t           stat,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      removed_node,
  output logic [1:0]      error_code,
  output logic            list_empty,
  output logic [7:0]      head_node
);

  localparam int unsigned IW = (NODE_SLOTS > 2) ? $clog2(NODE_SLOTS) : 1;

  // 8-bit index modulo NODE_SLOTS by shifted compare-subtract
  function automatic logic [IW-1:0] to_slot(input logic [7:0] v);
    logic [7:0] acc;
    acc = v;
    for (int k = 7; k >= 0; k--) begin
      if (32'(acc) >= (32'(NODE_SLOTS) << k)) begin
        acc = acc - 8'(32'(NODE_SLOTS) << k);
      end
    end
    return IW'(acc);
  endfunction

  logic [IW-1:0] next_mem [NODE_SLOTS];
  logic [IW-1:0] prev_mem [NODE_SLOTS];
  logic [IW-1:0] next_rd, prev_rd;

  cmd_t          cmd;
  logic [IW-1:0] node_r, ref_r, head, t_r, nh_save;
  logic          empty;

  cmd_t          cmd_in;
  logic [IW-1:0] ref_in, rd_ref, rd_addr, t_sel, ref_eff;
  logic          rd_en, is_before, is_insert, is_remove, single;
  logic          nx_we, pv_we;
  logic [IW-1:0] nx_wa, nx_wd, pv_wa, pv_wd;
  logic [IW-1:0] head_next, removed_val;
  logic          empty_next, fin;
  logic [1:0]    err_val;

  assign cmd_in = cmd_t'(command);
  assign ref_in = to_slot(referent);

  assign is_insert = cmd inside {CMD_INS_TAIL, CMD_INS_HEAD, CMD_INS_BEFORE, CMD_INS_AFTER};
  assign is_remove = cmd inside {CMD_REMOVE_NODE, CMD_REMOVE_HEAD, CMD_REMOVE_TAIL};
  assign is_before = cmd inside {CMD_INS_TAIL, CMD_INS_HEAD, CMD_INS_BEFORE};
  assign ref_eff   = (cmd inside {CMD_INS_BEFORE, CMD_INS_AFTER}) ? ref_r : head;
  assign single    = (head == nh_save);

  assign stat.in_skip    = (cmd_in inside {CMD_REMOVE_NODE, CMD_REMOVE_HEAD, CMD_REMOVE_TAIL})
                           ? empty : !(cmd_in inside {CMD_INS_TAIL, CMD_INS_HEAD,
                                                       CMD_INS_BEFORE, CMD_INS_AFTER});
  assign stat.cur_insert = is_insert;
  assign stat.out_free   = !out_valid || !out_stall;

  always_comb begin
    case (cmd)
      CMD_REMOVE_NODE: t_sel = node_r;
      CMD_REMOVE_HEAD: t_sel = head;
      default:         t_sel = prev_rd;
    endcase
  end

  assign rd_ref  = (cmd_in inside {CMD_INS_BEFORE, CMD_INS_AFTER}) ? ref_in : head;
  assign rd_addr = ctl.fetch ? t_sel : rd_ref;
  assign rd_en   = ctl.accept || (ctl.fetch && !is_insert);

  // link store writes
  always_comb begin
    nx_we = 1'b0;
    pv_we = 1'b0;
    nx_wa = node_r;
    nx_wd = node_r;
    pv_wa = node_r;
    pv_wd = node_r;
    if (ctl.fetch && is_insert) begin
      nx_we = 1'b1;
      pv_we = 1'b1;
      if (!empty) begin
        nx_wd = is_before ? ref_eff : next_rd;
        pv_wd = is_before ? prev_rd : ref_eff;
      end
    end else if (ctl.fin_link && !empty) begin
      nx_we = 1'b1;
      pv_we = 1'b1;
      nx_wa = is_before ? prev_rd : ref_eff;
      pv_wa = is_before ? ref_eff : next_rd;
    end else if (ctl.fin_unlink && !single) begin
      nx_we = 1'b1;
      pv_we = 1'b1;
      nx_wa = prev_rd;
      nx_wd = next_rd;
      pv_wa = next_rd;
      pv_wd = prev_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (nx_we) begin
      next_mem[nx_wa] <= nx_wd;
    end
    if (pv_we) begin
      prev_mem[pv_wa] <= pv_wd;
    end
    if (rd_en) begin
      next_rd <= next_mem[rd_addr];
      prev_rd <= prev_mem[rd_addr];
    end
  end

  // list state update and result
  always_comb begin
    head_next   = head;
    empty_next  = empty;
    err_val     = ERR_OK;
    removed_val = '0;
    if (ctl.fin_link) begin
      if (empty || cmd == CMD_INS_HEAD) begin
        head_next = node_r;
      end
      empty_next = 1'b0;
    end else if (ctl.fin_unlink) begin
      if (single) begin
        if (t_r != head) begin
          err_val = ERR_ABSENT;
        end else begin
          empty_next  = 1'b1;
          head_next   = '0;
          removed_val = t_r;
        end
      end else begin
        removed_val = t_r;
        if (head == t_r) begin
          head_next = next_rd;
        end
      end
    end else if (ctl.fin_reply) begin
      if (is_remove) begin
        err_val = ERR_EMPTY;
      end
    end
  end

  assign fin = ctl.fin_link || ctl.fin_unlink || ctl.fin_reply;

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      empty     <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      head      <= head_next;
      empty     <= empty_next;
      out_valid <= fin || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd    <= cmd_in;
      node_r <= to_slot(node);
      ref_r  <= ref_in;
    end
    if (ctl.fetch) begin
      t_r     <= t_sel;
      nh_save <= next_rd;
    end
    if (fin) begin
      removed_node <= 8'(removed_val);
      error_code   <= err_val;
      list_empty   <= empty_next;
      head_node    <= 8'(head_next);
    end
  end

endmodule

`default_nettype wire

@@ rtl/circular_doubly_linked_list_engine_core.sv @@
// ----------------------------------------------------------------------------
// circular_doubly_linked_list_engine_core
// Circular doubly linked list over a pool of node slots, one command per beat.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries command, node and referent; the
// output channel (out_valid/out_stall) returns removed_node, error_code,
// list_empty and head_node, one result beat per command beat.
// Inserts and removes pass through an accept, a fetch and a final cycle on
// the way to the result: the accept cycle issues the first read of both link
// stores, the fetch cycle issues the second read (removes) or the first link
// write (inserts), and the final cycle does the last link write and loads the
// result register. The link stores have one write and one registered read
// port each, which is why the reads and writes are spread this way.
// A remove from an empty list and the unused command code skip the link
// stores and the fetch cycle. A new command is accepted once the
// previous one has reached the result register, so a stall on the output
// does not block the next accept; that next command then holds in its final
// cycle until the result register is free. Reset empties the list and drops
// any pending result; link contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "circular_doubly_linked_list_engine_core_macros.svh"

module circular_doubly_linked_list_engine_core import cdll_pkg::*; #(
  parameter int unsigned NODE_SLOTS = NODE_SLOTS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] command,
  input  wire logic [7:0] node,
  input  wire logic [7:0] referent,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      removed_node,
  output logic [1:0]      error_code,
  output logic            list_empty,
  output logic [7:0]      head_node
);

  ctrl_t ctl;
  stat_t stat;

  cdll_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctl      (ctl)
  );

  cdll_dp #(
    .NODE_SLOTS (NODE_SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .command      (command),
    .node         (node),
    .referent     (referent),
    .ctl          (ctl),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .removed_node (removed_node),
    .error_code   (error_code),
    .list_empty   (list_empty),
    .head_node    (head_node)
  );

  `CDLL_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall, "accept while busy")
  `CDLL_ASSERT_SAME(a_single_step, clk, rst, 1'b1, $onehot0({ctl.accept, ctl.fetch, ctl.fin_link, ctl.fin_unlink, ctl.fin_reply}), "overlapping steps")
  `CDLL_ASSERT_SAME(a_empty_err, clk, rst, out_valid && error_code == ERR_EMPTY, list_empty && removed_node == 8'd0, "empty error on nonempty list")
  `CDLL_ASSERT_SAME(a_empty_head, clk, rst, out_valid && list_empty, head_node == 8'd0, "empty list with nonzero head")

endmodule

`default_nettype wire

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Drives list commands into the linked list engine and checks every result
// beat against a local model of the ring. Directed cases cover the empty and
// one-node lists and every insert and remove form. Random traffic then grows
// and shrinks the list, fills the whole pool, and finishes with re-inserted
// members and stray referents. Both sides idle at random, and the output is
// held off for a long stretch once.
// ----------------------------------------------------------------------------
module tb;
  import cdll_pkg::*;

  typedef struct packed {
    logic [7:0] removed;
    logic [1:0] err;
    logic       empty;
    logic [7:0] head;
  } list_reply_t;

  localparam logic [2:0] CMD_SPARE = 3'd7;
  localparam cmd_t INS_OPS [4] = '{CMD_INS_TAIL, CMD_INS_HEAD, CMD_INS_BEFORE, CMD_INS_AFTER};
  localparam cmd_t REM_OPS [3] = '{CMD_REMOVE_NODE, CMD_REMOVE_HEAD, CMD_REMOVE_TAIL};

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [2:0] command;
  logic [7:0] node;
  logic [7:0] referent;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] removed_node;
  logic [1:0] error_code;
  logic       list_empty;
  logic [7:0] head_node;

  // ring model
  logic [7:0]   link_nxt [256];
  logic [7:0]   link_prv [256];
  logic [7:0]   ring_head = 8'd0;
  logic         ring_void = 1'b1;
  bit   [255:0] touched = '0;
  bit   [255:0] on_ring;
  logic [7:0]   ring_q [$];

  list_reply_t  reply_q [$];
  list_reply_t  want;
  int           err_cnt = 0;
  bit           tx_idle = 1'b1;
  bit           rx_idle = 1'b1;
  int           rx_hold_req = 0;

  circular_doubly_linked_list_engine_core uut (
    .clk, .rst, .in_valid, .in_stall, .command, .node, .referent,
    .out_valid, .out_stall, .removed_node, .error_code, .list_empty, .head_node
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void form_ring(logic [7:0] n);
    link_nxt[n] = n;
    link_prv[n] = n;
    ring_head = n;
    ring_void = 1'b0;
    touched[n] = 1'b1;
  endfunction

  function automatic void splice_before(logic [7:0] n, logic [7:0] r);
    link_nxt[n] = r;
    link_prv[n] = link_prv[r];
    link_nxt[link_prv[r]] = n;
    link_prv[r] = n;
    touched[n] = 1'b1;
  endfunction

  function automatic void splice_after(logic [7:0] n, logic [7:0] r);
    link_prv[n] = r;
    link_nxt[n] = link_nxt[r];
    link_prv[link_nxt[r]] = n;
    link_nxt[r] = n;
    touched[n] = 1'b1;
  endfunction

  function automatic logic [1:0] detach(logic [7:0] t);
    if (ring_head == link_nxt[ring_head]) begin
      if (ring_head != t) return ERR_ABSENT;
      ring_void = 1'b1;
      ring_head = 8'd0;
    end else begin
      if (ring_head == t) ring_head = link_nxt[t];
      link_nxt[link_prv[t]] = link_nxt[t];
      link_prv[link_nxt[t]] = link_prv[t];
    end
    return ERR_OK;
  endfunction

  function automatic list_reply_t apply_cmd(logic [2:0] c, logic [7:0] n, logic [7:0] r);
    list_reply_t rep;
    logic [7:0]  t;
    rep.removed = 8'd0;
    rep.err = ERR_OK;
    case (c)
      CMD_INS_TAIL, CMD_INS_HEAD: begin
        if (ring_void) form_ring(n);
        else splice_before(n, ring_head);
        if (c == CMD_INS_HEAD) ring_head = n;
      end
      CMD_INS_BEFORE: begin
        if (ring_void) form_ring(n);
        else splice_before(n, r);
      end
      CMD_INS_AFTER: begin
        if (ring_void) form_ring(n);
        else splice_after(n, r);
      end
      CMD_REMOVE_NODE, CMD_REMOVE_HEAD, CMD_REMOVE_TAIL: begin
        if (ring_void) begin
          rep.err = ERR_EMPTY;
        end else begin
          if (c == CMD_REMOVE_NODE) t = n;
          else if (c == CMD_REMOVE_HEAD) t = ring_head;
          else t = link_prv[ring_head];
          rep.err = detach(t);
          if (rep.err == ERR_OK) rep.removed = t;
        end
      end
      default: ;
    endcase
    rep.empty = ring_void;
    rep.head = ring_head;
    return rep;
  endfunction

  function automatic void scan_ring();
    logic [7:0] p;
    ring_q.delete();
    on_ring = '0;
    if (!ring_void) begin
      p = ring_head;
      while (!on_ring[p]) begin
        on_ring[p] = 1'b1;
        ring_q.push_back(p);
        p = link_nxt[p];
      end
    end
  endfunction

  function automatic logic [7:0] pick_free();
    logic [7:0] s;
    s = 8'($urandom_range(0, 255));
    while (on_ring[s]) s++;
    return s;
  endfunction

  // a slot whose links were written but which is off the ring
  function automatic bit find_stray(output logic [7:0] s);
    logic [7:0] p;
    p = 8'($urandom_range(0, 255));
    s = 8'd0;
    for (int k = 0; k < 256; k++) begin
      if (touched[p] && !on_ring[p]) begin
        s = p;
        return 1'b1;
      end
      p++;
    end
    return 1'b0;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic issue_cmd(logic [2:0] c, logic [7:0] n, logic [7:0] r);
    int gap;
    gap = tx_idle ? $urandom_range(0, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= c;
    node <= n;
    referent <= r;
    do @(posedge clk); while (in_stall);
    reply_q.push_back(apply_cmd(c, n, r));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
  endtask

  task automatic random_step(int target, bit wild);
    logic [2:0] c;
    logic [7:0] n, r, s;
    int         sz, roll;
    scan_ring();
    sz = ring_q.size();
    n = 8'($urandom_range(0, 255));
    r = 8'($urandom_range(0, 255));
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      c = CMD_SPARE;
    end else if (sz < 256 && (sz == 0 ? roll < 80 : (sz < target ? roll < 90 : roll < 30))) begin
      c = INS_OPS[$urandom_range(0, 3)];
      n = pick_free();
      if (sz > 0 && (c == CMD_INS_BEFORE || c == CMD_INS_AFTER))
        r = ring_q[$urandom_range(0, sz - 1)];
    end else begin
      c = REM_OPS[$urandom_range(0, 2)];
      if (c == CMD_REMOVE_NODE && (sz > 1 || (sz == 1 && $urandom_range(0, 1))))
        n = ring_q[$urandom_range(0, sz - 1)];
    end
    if (wild && sz > 0 && $urandom_range(0, 2) == 0) begin
      roll = $urandom_range(0, 2);
      if (roll == 0) begin
        c = INS_OPS[$urandom_range(0, 3)];
        n = ring_q[$urandom_range(0, sz - 1)];
        r = ring_q[$urandom_range(0, sz - 1)];
      end else if (find_stray(s)) begin
        if (roll == 1) begin
          c = INS_OPS[$urandom_range(2, 3)];
          r = s;
        end else if (sz > 1) begin
          c = CMD_REMOVE_NODE;
          n = s;
        end
      end
    end
    issue_cmd(c, n, r);
  endtask

  task automatic test_empty_list_removes();
    issue_cmd(CMD_REMOVE_HEAD, 8'h00, 8'hFF);
    issue_cmd(CMD_REMOVE_TAIL, 8'hFF, 8'h00);
    issue_cmd(CMD_REMOVE_NODE, 8'h5A, 8'hA5);
    issue_cmd(CMD_SPARE, 8'hFF, 8'hFF);
  endtask

  task automatic test_single_node_ring();
    issue_cmd(CMD_INS_TAIL, 8'hFF, 8'h3C);
    issue_cmd(CMD_REMOVE_NODE, 8'h00, 8'h00);
    issue_cmd(CMD_REMOVE_NODE, 8'hFF, 8'hFF);
    issue_cmd(CMD_INS_BEFORE, 8'h00, 8'h77);
    issue_cmd(CMD_REMOVE_TAIL, 8'hC3, 8'h00);
    issue_cmd(CMD_INS_AFTER, 8'h80, 8'h12);
    issue_cmd(CMD_REMOVE_HEAD, 8'h01, 8'hFE);
  endtask

  task automatic test_relative_inserts();
    issue_cmd(CMD_INS_HEAD, 8'h01, 8'h99);
    issue_cmd(CMD_INS_TAIL, 8'hFE, 8'h00);
    issue_cmd(CMD_INS_HEAD, 8'h02, 8'hFF);
    issue_cmd(CMD_INS_BEFORE, 8'h10, 8'hFE);
    issue_cmd(CMD_INS_AFTER, 8'h20, 8'h02);
    issue_cmd(CMD_INS_AFTER, 8'h30, 8'hFE);
    issue_cmd(CMD_INS_BEFORE, 8'h40, 8'h02);
    issue_cmd(CMD_SPARE, 8'h00, 8'h00);
    issue_cmd(CMD_REMOVE_TAIL, 8'h00, 8'h00);
    issue_cmd(CMD_REMOVE_HEAD, 8'h00, 8'h00);
    issue_cmd(CMD_REMOVE_NODE, 8'h10, 8'h00);
    issue_cmd(CMD_REMOVE_NODE, ring_head, 8'h00);
    while (!ring_void) issue_cmd(CMD_REMOVE_HEAD, 8'($urandom_range(0, 255)), 8'h00);
  endtask

  // output held off while the sender keeps offering, so the input backs up
  task automatic test_output_backlog();
    wait_drained();
    tx_idle = 1'b0;
    rx_hold_req = 60;
    repeat (12) random_step(8, 1'b0);
    wait_drained();
    tx_idle = 1'b1;
  endtask

  task automatic test_random_ops();
    int span [6] = '{120, 80, 200, 400, 150, 50};
    int goal [6] = '{4, 1, 32, 256, 12, 2};
    foreach (span[p]) begin
      for (int i = 0; i < span[p]; i++) begin
        if (i % 50 == 0) begin
          tx_idle = $urandom_range(0, 3) != 0;
          rx_idle = $urandom_range(0, 3) != 0;
        end
        random_step(goal[p], 1'b0);
      end
      if (p % 2 == 1) wait_drained();
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // re-inserted members, off-ring referents and off-ring removes
  task automatic test_broken_sequences();
    repeat (80) random_step(6, 1'b1);
    wait_drained();
  endtask

  initial begin
    int pause;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req > 0) begin
        pause = rx_hold_req;
        rx_hold_req = 0;
      end else begin
        pause = rx_idle ? $urandom_range(0, 4) : 0;
      end
      if (pause > 0) begin
        out_stall <= 1'b1;
        repeat (pause) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !rst));
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (reply_q.size() == 0) begin
        flag_mismatch("result beat with nothing expected");
      end else begin
        want = reply_q.pop_front();
        if (removed_node !== want.removed)
          flag_mismatch($sformatf("removed_node %0d, want %0d", removed_node, want.removed));
        if (error_code !== want.err)
          flag_mismatch($sformatf("error_code %0d, want %0d", error_code, want.err));
        if (list_empty !== want.empty)
          flag_mismatch($sformatf("list_empty %0d, want %0d", list_empty, want.empty));
        if (head_node !== want.head)
          flag_mismatch($sformatf("head_node %0d, want %0d", head_node, want.head));
      end
    end
  end

  initial begin
    #2000000;
    $display("[circular_doubly_linked_list_engine_core] ERROR");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    command = CMD_INS_TAIL;
    node = 8'd0;
    referent = 8'd0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_list_removes();
    test_single_node_ring();
    test_relative_inserts();
    test_output_backlog();
    test_random_ops();
    test_broken_sequences();
    wait_drained();
    repeat (8) @(posedge clk);
    if (err_cnt == 0)
      $display("[circular_doubly_linked_list_engine_core] OK");
    else
      $display("[circular_doubly_linked_list_engine_core] ERROR");
    $finish;
  end

endmodule
